// ===== sv/hdbn_pkg.sv =====
package hdbn_pkg;

    // Highest code order the encoder substitutes for; larger settings clamp here.
    localparam int MAX_ORDER   = 7;
    localparam int MIN_ORDER   = 2;
    localparam int ORD_W       = 3;
    localparam int PEND_W      = $clog2(MAX_ORDER + 1);
    localparam int LEN_W       = $clog2(MAX_ORDER + 2);
    localparam int QUEUE_DEPTH = 4;
    localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(3);

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        KIND_SPACE = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_BAL   = 2'd2,
        KIND_VIOL  = 2'd3
    } kind_t;

    // One burst of line symbols: len symbols, all spaces except an optional
    // B at b_idx and the final symbol of kind tail_kind. B and the final
    // pulse share the polarity pol.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              b_en;
        logic [PEND_W-1:0] b_idx;
        logic              pol;
        kind_t             tail_kind;
    } job_t;

endpackage

// ===== sv/hdbn_line_encoder.sv =====
// HDBn bipolar line encoder.
// Input stream (s_*): one transaction per message bit; s_tuser flags a flush
// at the end of a message, which sends any held zeros as spaces.
// Output stream (m_*): one transaction per line symbol; m_tdata carries the
// pulse polarity, m_tuser the symbol kind (space, mark, B, V) and m_tlast
// marks the final symbol caused by one input transaction.
// cfg_wr_en / cfg_wr_data program the code order (reset 3, HDB3); write only
// while the encoder is idle. Orders outside 2..MAX_ORDER clamp.
// An accepted input that sends symbols queues a job; m_tvalid rises when it
// loads the output register. A held zero sends nothing until its run resolves.
// Throughput: one input per cycle while the job queue has room; the output
// side sends one symbol per cycle while m_tready is high, so a substitution
// of order+1 symbols holds the output longer and the queue of DEPTH jobs absorbs it.
// Reset clears the polarity (first pulse positive), parity (first
// substitution has no B), held zeros, the queue and the output register.
// When the receiver stalls, the output register holds its symbol, the queue
// fills, and s_tready drops once DEPTH jobs are waiting.
module hdbn_line_encoder
    import hdbn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [ORD_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] data_bit, [7:1] zero
    input  logic [0:0]       s_tuser,   // [0] action (1 = flush)
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] positive, [1] negative, [7:2] zero
    output logic [1:0]       m_tuser,   // [1:0] symbol_kind
    output logic             m_tlast
);

    logic  in_fire;
    logic  push, pop, full, empty;
    job_t  push_job, head_job;
    logic  out_pos, out_neg;
    kind_t out_kind;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    // Classify each transaction and track polarity, parity and held zeros.
    hdbn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .action      (s_tuser[0]),
        .data_bit    (s_tdata[0]),
        .push        (push),
        .job         (push_job)
    );

    // Hold pending symbol bursts between the two sides.
    hdbn_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_job (head_job)
    );

    // Expand each burst into line symbols, one per cycle while the receiver is ready.
    hdbn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pos   (out_pos),
        .out_neg   (out_neg),
        .out_kind  (out_kind),
        .out_last  (m_tlast)
    );

    assign m_tdata = {6'b0, out_neg, out_pos};
    assign m_tuser = out_kind;

endmodule

// ===== sv/hdbn_front.sv =====
module hdbn_front
    import hdbn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [ORD_W-1:0] cfg_wr_data,
    input  logic             in_fire,
    input  logic             action,
    input  logic             data_bit,
    output logic             push,
    output job_t             job
);

    logic [ORD_W-1:0]  order_reg;
    logic              lp_reg, lp_next;
    logic              odd_reg, odd_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PEND_W-1:0] n_eff;
    logic              subst;

    // Clamp the programmed order into the supported range.
    always_comb begin
        if (int'(order_reg) < MIN_ORDER) begin
            n_eff = PEND_W'(MIN_ORDER);
        end else if (int'(order_reg) > MAX_ORDER) begin
            n_eff = PEND_W'(MAX_ORDER);
        end else begin
            n_eff = PEND_W'(order_reg);
        end
    end

    assign subst = (pend_reg >= n_eff);

    always_comb begin
        lp_next        = lp_reg;
        odd_next       = odd_reg;
        pend_next      = pend_reg;
        push           = 1'b0;
        job.len        = LEN_W'(pend_reg) + LEN_W'(1);
        job.b_en       = 1'b0;
        job.b_idx      = pend_reg - n_eff;
        job.pol        = lp_reg;
        job.tail_kind  = KIND_SPACE;
        if (in_fire) begin
            if (action == ACT_FLUSH) begin
                // Send the held zeros as plain spaces.
                job.len   = LEN_W'(pend_reg);
                push      = (pend_reg != '0);
                pend_next = '0;
            end else if (data_bit) begin
                lp_next       = ~lp_reg;
                odd_next      = ~odd_reg;
                pend_next     = '0;
                push          = 1'b1;
                job.pol       = ~lp_reg;
                job.tail_kind = KIND_MARK;
            end else if (subst) begin
                // Even pulse count since the last V: lead with a B pulse.
                job.b_en      = ~odd_reg;
                lp_next       = odd_reg ? lp_reg : ~lp_reg;
                job.pol       = odd_reg ? lp_reg : ~lp_reg;
                job.tail_kind = KIND_VIOL;
                odd_next      = 1'b0;
                pend_next     = '0;
                push          = 1'b1;
            end else begin
                pend_next = pend_reg + PEND_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
            lp_reg    <= 1'b0;
            odd_reg   <= 1'b1;
            pend_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                order_reg <= cfg_wr_data;
            end
            lp_reg   <= lp_next;
            odd_reg  <= odd_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== sv/hdbn_queue.sv =====
module hdbn_queue
    import hdbn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/hdbn_back.sv =====
module hdbn_back
    import hdbn_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  empty,
    input  job_t  head_job,
    output logic  pop,
    output logic  out_valid,
    input  logic  out_ready,
    output logic  out_pos,
    output logic  out_neg,
    output kind_t out_kind,
    output logic  out_last
);

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             pos_reg, neg_reg, last_reg;
    kind_t            kind_reg;
    logic             load;
    logic             is_tail;
    kind_t            sym_kind;

    // Refill the output register whenever the queue holds a job and the register is empty or being drained.
    assign load    = !empty && (!valid_reg || out_ready);
    assign is_tail = (idx_reg == head_job.len - LEN_W'(1));
    assign pop     = load && is_tail;

    always_comb begin
        if (is_tail) begin
            sym_kind = head_job.tail_kind;
        end else if (head_job.b_en && idx_reg == LEN_W'(head_job.b_idx)) begin
            sym_kind = KIND_BAL;
        end else begin
            sym_kind = KIND_SPACE;
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_tail ? '0 : idx_reg + LEN_W'(1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= sym_kind;
            pos_reg  <= (sym_kind != KIND_SPACE) && head_job.pol;
            neg_reg  <= (sym_kind != KIND_SPACE) && !head_job.pol;
            last_reg <= is_tail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pos   = pos_reg;
    assign out_neg   = neg_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule
